FILE: design/rtp_pkg.sv
// Shared types, constants and helper functions for the RGB triplet text parser.
package rtp_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned ACC_W  = 9;
    localparam int unsigned MUL_W  = 12;

    localparam logic [CHAR_W-1:0] CH_COMMA = 8'd44;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'd43;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;

    localparam logic [ACC_W-1:0] ACC_MAX   = 9'd255;
    localparam logic [ACC_W-1:0] SAT_LIMIT = 9'd256;

    localparam logic [1:0] LAST_FIELD = 2'd2;

    typedef enum logic [2:0] {
        PH_SPACE  = 3'd0,
        PH_SIGN   = 3'd1,
        PH_DIGITS = 3'd2,
        PH_ENDED  = 3'd3
    } t_phase;

    typedef struct packed {
        logic              valid_res;
        logic [CHAR_W-1:0] red;
        logic [CHAR_W-1:0] green;
        logic [CHAR_W-1:0] blue;
    } t_result;

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        is_space = c inside {8'd32, [8'd9:8'd13]};
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        is_digit = c inside {[CH_ZERO:CH_NINE]};
    endfunction

    // A field is complete when it holds digits, fits a byte, and is not negative nonzero.
    function automatic logic field_ok(input t_phase ph, input logic neg,
                                      input logic [ACC_W-1:0] acc);
        field_ok = ((ph == PH_DIGITS) || (ph == PH_ENDED)) && (acc <= ACC_MAX)
                   && !(neg && (acc != '0));
    endfunction

endpackage

FILE: design/rtp_scanner.sv
// Per-byte field scanner: holds the parse state and forms the result on the final byte.
module rtp_scanner
    import rtp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [CHAR_W-1:0] i_char,
    input  logic              i_last,
    output t_result           o_result
);

    logic [1:0]        r_fidx,   n_fidx;
    t_phase            r_phase,  n_phase;
    logic              r_neg,    n_neg;
    logic [ACC_W-1:0]  r_acc,    n_acc;
    logic [CHAR_W-1:0] r_first,  n_first;
    logic [CHAR_W-1:0] r_second, n_second;
    logic              r_failed, n_failed;

    logic              cur_ok;
    logic [MUL_W-1:0]  mac;
    logic              valid;

    assign cur_ok = field_ok(r_phase, r_neg, r_acc);
    // acc * 10 + digit as two shifts and two adds
    assign mac = ({3'b000, r_acc} << 3) + ({3'b000, r_acc} << 1)
                 + MUL_W'(i_char - CH_ZERO);

    always_comb begin
        n_fidx   = r_fidx;
        n_phase  = r_phase;
        n_neg    = r_neg;
        n_acc    = r_acc;
        n_first  = r_first;
        n_second = r_second;
        n_failed = r_failed;
        if (!r_failed) begin
            if ((i_char == CH_COMMA) && (r_fidx < LAST_FIELD)) begin
                if (!cur_ok) begin
                    n_failed = 1'b1;
                end else begin
                    if (r_fidx == 2'd0) begin
                        n_first = r_acc[CHAR_W-1:0];
                    end else begin
                        n_second = r_acc[CHAR_W-1:0];
                    end
                    n_fidx  = r_fidx + 2'd1;
                    n_phase = PH_SPACE;
                    n_neg   = 1'b0;
                    n_acc   = '0;
                end
            end else if (r_phase == PH_ENDED) begin
                // ignore the rest of a field closed by a zero byte
            end else if (i_char == CH_COMMA) begin
                n_failed = 1'b1;
            end else if (i_char == CH_NUL) begin
                if (r_phase == PH_DIGITS) begin
                    n_phase = PH_ENDED;
                end else begin
                    n_failed = 1'b1;
                end
            end else if ((r_phase == PH_SPACE) && is_space(i_char)) begin
                // skip leading whitespace
            end else if ((r_phase == PH_SPACE)
                         && ((i_char == CH_PLUS) || (i_char == CH_MINUS))) begin
                n_neg   = (i_char == CH_MINUS);
                n_phase = PH_SIGN;
            end else if (is_digit(i_char)) begin
                n_acc   = (mac > MUL_W'(SAT_LIMIT)) ? SAT_LIMIT : mac[ACC_W-1:0];
                n_phase = PH_DIGITS;
            end else begin
                n_failed = 1'b1;
            end
        end
    end

    assign valid = !n_failed && (n_fidx == LAST_FIELD) && field_ok(n_phase, n_neg, n_acc);

    always_comb begin
        o_result.valid_res = valid;
        o_result.red       = valid ? n_first  : '0;
        o_result.green     = valid ? n_second : '0;
        o_result.blue      = valid ? n_acc[CHAR_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_fidx   <= '0;
            r_phase  <= PH_SPACE;
            r_neg    <= 1'b0;
            r_acc    <= '0;
            r_first  <= '0;
            r_second <= '0;
            r_failed <= 1'b0;
        end else if (i_step) begin
            r_fidx   <= n_fidx;
            r_phase  <= n_phase;
            r_neg    <= n_neg;
            r_acc    <= n_acc;
            r_first  <= n_first;
            r_second <= n_second;
            r_failed <= n_failed;
        end
    end

endmodule

FILE: design/rtp_out_buf.sv
// Result register that holds a finished result until the receiver takes it.
module rtp_out_buf
    import rtp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_valid,
    output logic    o_free,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_result <= i_result;
        end
    end

endmodule

FILE: design/rgb_triplet_text_parser.sv
// Top level of the RGB triplet text parser: input register, scanner and result register.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one payload byte per transfer on
//   i_in_char, with i_last_char high on the final byte of a message. Output channel
//   (o_out_valid / i_out_ready) carries one result per message: o_valid_res and the
//   red, green and blue bytes, all zero when the text is not three fields in 0..255.
//   Only the transfer of a final byte produces a result; other bytes produce none.
// Path: a final byte passes through the input register and then the result register,
//   waiting in the input register while the result register still holds a result.
// Throughput: one byte per cycle, except that a final byte waits while the result register
//   is busy. The scanner state update for a byte is a single pass (multiply-by-ten,
//   saturate, compare), so bytes stream back to back.
// Reset (i_rst_n low, synchronous): drop any held byte and result and return the
//   scanner to the start of the first field. The scanner also restarts after every
//   final byte.
// Stall: while a result waits on i_out_ready, ordinary bytes keep flowing through the
//   scanner; a final byte holds in the input register until the result register frees,
//   and o_in_ready drops only in that case.
module rgb_triplet_text_parser
    import rtp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [CHAR_W-1:0] i_in_char,
    input  logic              i_last_char,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_valid_res,
    output logic [CHAR_W-1:0] o_red,
    output logic [CHAR_W-1:0] o_green,
    output logic [CHAR_W-1:0] o_blue
);

    // Input register
    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_last;

    logic    consume;
    logic    out_free;
    t_result scan_result;
    t_result out_result;

    // Advance a held byte into the scanner unless it is final and the result slot is busy.
    assign consume    = r_in_valid && (!r_in_last || out_free);
    assign o_in_ready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_char <= i_in_char;
            r_in_last <= i_last_char;
        end
    end

    rtp_scanner u_scanner (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (consume),
        .i_char   (r_in_char),
        .i_last   (r_in_last),
        .o_result (scan_result)
    );

    rtp_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (consume && r_in_last),
        .i_result (scan_result),
        .i_ready  (i_out_ready),
        .o_valid  (o_out_valid),
        .o_free   (out_free),
        .o_result (out_result)
    );

    assign o_valid_res = out_result.valid_res;
    assign o_red       = out_result.red;
    assign o_green     = out_result.green;
    assign o_blue      = out_result.blue;

endmodule

FILE: design/rtp_checker.sv
// Port-level checker for the RGB triplet text parser and its bind.
module rtp_checker
    import rtp_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic [CHAR_W-1:0] i_in_char,
    input logic              i_last_char,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic              o_valid_res,
    input logic [CHAR_W-1:0] o_red,
    input logic [CHAR_W-1:0] o_green,
    input logic [CHAR_W-1:0] o_blue
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending right after reset");

    a_invalid_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_valid_res) |-> (o_red == '0 && o_green == '0 && o_blue == '0))
        else $error("rejected message carries nonzero components");

    a_ready_when_empty: assert property (@(posedge i_clk)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while result slot is empty");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_valid_res) && $stable(o_red)
             && $stable(o_green) && $stable(o_blue)))
        else $error("stalled result changed");

endmodule

bind rgb_triplet_text_parser rtp_checker u_rtp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_char   (i_in_char),
    .i_last_char (i_last_char),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_valid_res (o_valid_res),
    .o_red       (o_red),
    .o_green     (o_green),
    .o_blue      (o_blue)
);
